[design/note_saw_oscillator_top_assert.svh]
// Assertion macros shared by the oscillator RTL.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef NOTE_SAW_OSCILLATOR_TOP_ASSERT_SVH
`define NOTE_SAW_OSCILLATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define NSO_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define NSO_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/nso_pkg.sv]
// ----------------------------------------------------------------------------
// nso_pkg
// Shared constants, types and the pitch-to-step table of the saw oscillator.
// ----------------------------------------------------------------------------
package nso_pkg;

	localparam int SAMPLE_RATE = 48000;
	localparam int PHASE_BITS  = 32;

	localparam int PITCH_W = 7;
	localparam int VEL_W   = 16;
	localparam int GAIN_W  = 16;
	localparam int SAMPLE_W = 16;
	localparam int NUM_PITCHES = 128;

	// gain = (2*vel + 5) / 10 through a reciprocal multiply, exact for x < 2^18
	localparam int GAIN_X_W     = VEL_W + 2;
	localparam int GAIN_RECIP   = 209716;
	localparam int GAIN_SHIFT   = 21;
	localparam int GAIN_PROD_W  = 2 * GAIN_X_W;

	// gain scaled by 32767
	localparam int GAINX_W = GAIN_W + 15;
	localparam int MAG_W   = 32;
	localparam int PROD_W  = MAG_W + GAINX_W;
	localparam int PROD_SHIFT = 47;

	// bring the phase to Q0.32
	localparam int P32_SH_R = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
	localparam int P32_SH_L = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		REQ_TICK     = 2'd0,
		REQ_NOTE_ON  = 2'd1,
		REQ_NOTE_OFF = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_ON,
		CMD_OFF
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t               kind;
		logic [PITCH_W-1:0]      pitch;
		logic [PHASE_BITS-1:0]   step;
		logic [GAIN_W-1:0]       gain;
	} cmd_t;

	typedef logic [PHASE_BITS-1:0] step_rom_t [NUM_PITCHES];

	// 2^(s/12) in Q2.30
	localparam logic [63:0] SEMITONE_Q30 [12] = '{
		64'd1073741824, 64'd1137589835, 64'd1205234447, 64'd1276901417,
		64'd1352829926, 64'd1433273380, 64'd1518500250, 64'd1608794974,
		64'd1704458901, 64'd1805811301, 64'd1913190429, 64'd2026954652
	};

	// step = floor(440 * 2^((p-69)/12) * 2^PHASE_BITS / SAMPLE_RATE)
	function automatic step_rom_t build_step_rom();
		step_rom_t   rom;
		logic [63:0] num;
		logic [63:0] step;
		int          n;
		int          oct;
		int          semi;
		int          e;
		for (int p = 0; p < NUM_PITCHES; p++) begin
			n    = p + 3;
			oct  = n / 12;
			semi = n % 12;
			num  = 64'd440 * SEMITONE_Q30[semi];
			e    = oct + PHASE_BITS - 36;
			if (e >= 0) begin
				step = (num << e) / SAMPLE_RATE;
			end else begin
				step = (num / SAMPLE_RATE) >> (-e);
			end
			rom[p] = step[PHASE_BITS-1:0];
		end
		return rom;
	endfunction

	localparam step_rom_t STEP_ROM = build_step_rom();

endpackage

[design/note_saw_oscillator_top.sv]
// ----------------------------------------------------------------------------
// note_saw_oscillator_top
// Monophonic sawtooth voice on a phase accumulator.
//
// Input channel (in_valid/in_ready): one word per request, req_type selects
// a sample tick, note-on (note_pitch, note_velocity) or note-off. Note-on
// with zero velocity and the unused request code are dropped.
// Output channel (out_valid/out_ready): one sample_out word per tick, none
// for note events.
// Throughput: one request word per cycle unless the receiver stalls. The
// phase add loops in phase_q; the sample math is a four-stage pipeline.
// Path: a tick accepted at the input passes the front register, the command
// queue, three arithmetic stages and the output register.
// Reset: the voice is silent, its state is zero and the queue is empty.
// Receiver stall: the output register holds its word and the back pipeline
// freezes; the front keeps accepting until its register and the two-entry
// command queue are full, then in_ready drops.
// ----------------------------------------------------------------------------
module note_saw_oscillator_top import nso_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          req_type,
	input  logic [PITCH_W-1:0]  note_pitch,
	input  logic [VEL_W-1:0]    note_velocity,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SAMPLE_W-1:0] sample_out
);

	logic f_valid, f_ready;
	cmd_t f_cmd;
	logic b_valid, b_ready;
	cmd_t b_cmd;

	nso_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.note_pitch    (note_pitch),
		.note_velocity (note_velocity),
		.cmd_valid     (f_valid),
		.cmd_ready     (f_ready),
		.cmd           (f_cmd)
	);

	nso_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_cmd),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_cmd)
	);

	nso_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (b_valid),
		.cmd_ready  (b_ready),
		.cmd        (b_cmd),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out)
	);

endmodule

[design/nso_front.sv]
// ----------------------------------------------------------------------------
// nso_front
// Accepts request words, drops zero-velocity note-ons and the unused code,
// finds the phase step and the note gain and hands a command to the queue.
// ----------------------------------------------------------------------------
module nso_front import nso_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [PITCH_W-1:0] note_pitch,
	input  logic [VEL_W-1:0]   note_velocity,
	output logic               cmd_valid,
	input  logic               cmd_ready,
	output cmd_t               cmd
);

	logic                    valid_s1;
	cmd_kind_t               kind_s1;
	logic [PITCH_W-1:0]      pitch_s1;
	logic [PHASE_BITS-1:0]   step_s1;
	logic [GAIN_PROD_W-1:0]  gprod_s1;

	logic                    in_fire;
	logic                    keep;
	cmd_kind_t               kind_d;
	logic [GAIN_X_W-1:0]     gain_x;

	assign in_ready = !valid_s1 || cmd_ready;
	assign in_fire  = in_valid && in_ready;
	assign gain_x   = {1'b0, note_velocity, 1'b0} + GAIN_X_W'(5);

	always_comb begin
		keep   = 1'b0;
		kind_d = CMD_TICK;
		case (req_t'(req_type))
			REQ_TICK: begin
				keep   = 1'b1;
				kind_d = CMD_TICK;
			end
			REQ_NOTE_ON: begin
				// zero velocity is a no-op
				keep   = (note_velocity != '0);
				kind_d = CMD_ON;
			end
			REQ_NOTE_OFF: begin
				keep   = 1'b1;
				kind_d = CMD_OFF;
			end
			default: begin
				keep   = 1'b0;
				kind_d = CMD_TICK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= keep;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1  <= kind_d;
			pitch_s1 <= note_pitch;
			step_s1  <= STEP_ROM[note_pitch];
			gprod_s1 <= GAIN_PROD_W'(gain_x) * GAIN_PROD_W'(GAIN_RECIP);
		end
	end

	assign cmd_valid  = valid_s1;
	assign cmd.kind   = kind_s1;
	assign cmd.pitch  = pitch_s1;
	assign cmd.step   = step_s1;
	assign cmd.gain   = GAIN_W'(gprod_s1 >> GAIN_SHIFT);

endmodule

[design/nso_queue.sv]
// ----------------------------------------------------------------------------
// nso_queue
// Short command FIFO between front and back; each side stalls on its own.
// ----------------------------------------------------------------------------
module nso_queue import nso_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_data
);

	`include "note_saw_oscillator_top_assert.svh"

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push_fire;
	logic              pop_fire;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QDEPTH - 1)) begin
			return '0;
		end
		return p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop_fire) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push_fire, pop_fire})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`NSO_CHECK(q_count_range, 1'b1, count_q <= QCNT_W'(QDEPTH), "queue count out of range")
	`NSO_CHECK_NEXT(q_count_hold, push_fire && pop_fire, $stable(count_q), "queue count moved")

endmodule

[design/nso_back.sv]
// ----------------------------------------------------------------------------
// nso_back
// Holds the voice, runs the phase accumulator and turns each tick into a
// sample through a short arithmetic pipeline ending in the output register.
// ----------------------------------------------------------------------------
module nso_back import nso_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  cmd_t                cmd,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SAMPLE_W-1:0] sample_out
);

	`include "note_saw_oscillator_top_assert.svh"

	// voice state
	logic                  voice_on_q;
	logic [PITCH_W-1:0]    held_pitch_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] step_q;
	logic [GAINX_W-1:0]    gainx_q;

	// pipeline
	logic                  vld_s1, act_s1;
	logic [31:0]           p32_s1;
	logic [GAINX_W-1:0]    gx_s1;
	logic                  vld_s2, act_s2, neg_s2;
	logic [MAG_W-1:0]      mag2_s2;
	logic [GAINX_W-1:0]    gx_s2;
	logic                  vld_s3, act_s3, neg_s3;
	logic [PROD_W-1:0]     prod_s3;
	logic                  out_valid_q;
	logic [SAMPLE_W-1:0]   sample_q;

	logic                  adv;
	logic                  pop;
	logic [31:0]           p32;
	logic [SAMPLE_W-1:0]   mag;

	assign adv       = !out_valid_q || out_ready;
	assign cmd_ready = adv;
	assign pop       = cmd_valid && adv;
	assign p32       = 32'((64'(phase_q) << P32_SH_L) >> P32_SH_R);
	assign mag       = SAMPLE_W'(prod_s3 >> PROD_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voice_on_q   <= 1'b0;
			held_pitch_q <= '0;
			phase_q      <= '0;
			step_q       <= '0;
			gainx_q      <= '0;
		end else if (pop) begin
			case (cmd.kind)
				CMD_ON: begin
					voice_on_q   <= 1'b1;
					held_pitch_q <= cmd.pitch;
					phase_q      <= '0;
					step_q       <= cmd.step;
					gainx_q      <= {cmd.gain, 15'b0} - GAINX_W'(cmd.gain);
				end
				CMD_OFF: begin
					if (cmd.pitch == held_pitch_q) begin
						voice_on_q <= 1'b0;
					end
				end
				CMD_TICK: begin
					// advance with wrap
					if (voice_on_q) begin
						phase_q <= phase_q + step_q;
					end
				end
				default: begin
					voice_on_q <= voice_on_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= pop && (cmd.kind == CMD_TICK);
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			out_valid_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1  <= voice_on_q;
			p32_s1  <= p32;
			gx_s1   <= gainx_q;

			act_s2  <= act_s1;
			neg_s2  <= !p32_s1[31];
			mag2_s2 <= p32_s1[31] ? (p32_s1 - 32'h8000_0000) : (32'h8000_0000 - p32_s1);
			gx_s2   <= gx_s1;

			act_s3  <= act_s2;
			neg_s3  <= neg_s2;
			prod_s3 <= PROD_W'(mag2_s2) * PROD_W'(gx_s2);

			if (!act_s3) begin
				sample_q <= '0;
			end else if (neg_s3) begin
				sample_q <= SAMPLE_W'(0) - mag;
			end else begin
				sample_q <= mag;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_q;

	`NSO_CHECK(b_sample_bound, out_valid_q,
		($signed(sample_q) <= 16'sd6553) && ($signed(sample_q) >= -16'sd6553),
		"sample magnitude above bound")
	`NSO_CHECK_NEXT(b_note_on_load, pop && (cmd.kind == CMD_ON),
		voice_on_q && (phase_q == '0), "note-on did not start the voice")

endmodule

[tb/tb_note_saw_oscillator_top.sv]
// ----------------------------------------------------------------------------
// tb_note_saw_oscillator_top
// Self-checking bench for the monophonic sawtooth voice. A directed table
// covers reset, extremes, ignored and unmatched events and the unused request
// code. Random note phrases with noise follow. Every sample word is checked
// against the table's expected value or an in-bench phase accumulator model,
// with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_note_saw_oscillator_top;
	timeunit 1ns;
	timeprecision 1ps;
	import nso_pkg::*;

	localparam int N_ITEMS      = 2000;
	localparam int QUIET_FROM   = 1750;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]          kind;
		logic [PITCH_W-1:0]  pitch;
		logic [VEL_W-1:0]    vel;
		logic                has_exp;
		logic [SAMPLE_W-1:0] exp_sample;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          req_type;
	logic [PITCH_W-1:0]  note_pitch;
	logic [VEL_W-1:0]    note_velocity;
	logic                out_valid;
	logic                out_ready;
	logic [SAMPLE_W-1:0] sample_out;

	// voice model state
	logic                  voice_active;
	logic [PITCH_W-1:0]    held_note;
	logic [PHASE_BITS-1:0] phase;
	logic [PHASE_BITS-1:0] phase_inc;
	logic [GAIN_W-1:0]     gain_q16;

	logic [SAMPLE_W-1:0] expected_samples[$];
	stim_row_t           directed_rows[$];
	logic [SAMPLE_W-1:0] want;
	int                  mismatches;
	int                  words_sent;
	int                  stall_cycles;
	bit                  quiet_tail;

	note_saw_oscillator_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.note_pitch    (note_pitch),
		.note_velocity (note_velocity),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.sample_out    (sample_out)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// 2^(s/12) in Q2.30
	function automatic logic [63:0] semitone_ratio(input int s);
		case (s)
			0:  return 64'd1073741824;
			1:  return 64'd1137589835;
			2:  return 64'd1205234447;
			3:  return 64'd1276901417;
			4:  return 64'd1352829926;
			5:  return 64'd1433273380;
			6:  return 64'd1518500250;
			7:  return 64'd1608794974;
			8:  return 64'd1704458901;
			9:  return 64'd1805811301;
			10: return 64'd1913190429;
			default: return 64'd2026954652;
		endcase
	endfunction

	// floor(440 * 2^((p-69)/12) * 2^PHASE_BITS / SAMPLE_RATE), octave by shift
	function automatic logic [PHASE_BITS-1:0] pitch_increment(input logic [PITCH_W-1:0] p);
		int          n;
		int          sh;
		logic [63:0] num;
		logic [63:0] inc;
		n   = int'(p) + 3;
		sh  = n / 12 + PHASE_BITS - 36;
		num = 64'd440 * semitone_ratio(n % 12);
		if (sh >= 0)
			inc = (num << sh) / SAMPLE_RATE;
		else
			inc = (num / SAMPLE_RATE) >> (-sh);
		return inc[PHASE_BITS-1:0];
	endfunction

	function automatic logic [SAMPLE_W-1:0] saw_sample(input logic [PHASE_BITS-1:0] ph,
			input logic [GAIN_W-1:0] g);
		logic [63:0] p32;
		logic [63:0] half;
		logic [63:0] span;
		logic [63:0] mag;
		logic        below;
		if (PHASE_BITS >= 32)
			p32 = 64'(ph) >> (PHASE_BITS - 32);
		else
			p32 = 64'(ph) << (32 - PHASE_BITS);
		half  = 64'd1 << 31;
		below = p32 < half;
		span  = below ? (half - p32) : (p32 - half);
		mag   = ((span * 2) * 64'(g) * 64'd32767) >> 48;
		return below ? (16'd0 - mag[15:0]) : mag[15:0];
	endfunction

	task automatic predict_word(input logic [1:0] kind, input logic [PITCH_W-1:0] pitch,
			input logic [VEL_W-1:0] vel, input logic has_exp,
			input logic [SAMPLE_W-1:0] exp_sample);
		logic [SAMPLE_W-1:0] s;
		logic [31:0]         g;
		case (kind)
			REQ_NOTE_ON: begin
				if (vel != '0) begin
					g            = (32'(vel) * 2 + 5) / 10;
					held_note    = pitch;
					phase_inc    = pitch_increment(pitch);
					gain_q16     = g[GAIN_W-1:0];
					phase        = '0;
					voice_active = 1'b1;
				end
			end
			REQ_NOTE_OFF: begin
				if (pitch == held_note)
					voice_active = 1'b0;
			end
			REQ_TICK: begin
				s = '0;
				if (voice_active) begin
					s     = saw_sample(phase, gain_q16);
					phase = phase + phase_inc;
				end
				expected_samples.push_back(has_exp ? exp_sample : s);
			end
			default: ;
		endcase
	endtask

	task automatic issue_word(input logic [1:0] kind, input logic [PITCH_W-1:0] pitch,
			input logic [VEL_W-1:0] vel, input logic has_exp,
			input logic [SAMPLE_W-1:0] exp_sample);
		int gap;
		if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 18);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid      <= 1'b1;
		req_type      <= kind;
		note_pitch    <= pitch;
		note_velocity <= vel;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_word(kind, pitch, vel, has_exp, exp_sample);
		words_sent++;
		quiet_tail = (words_sent >= QUIET_FROM);
	endtask

	task automatic add_row(input logic [1:0] kind, input int pitch, input int vel,
			input logic has_exp, input logic [SAMPLE_W-1:0] exp_sample);
		stim_row_t r;
		r.kind       = kind;
		r.pitch      = pitch[PITCH_W-1:0];
		r.vel        = vel[VEL_W-1:0];
		r.has_exp    = has_exp;
		r.exp_sample = exp_sample;
		directed_rows.push_back(r);
	endtask

	function automatic logic [VEL_W-1:0] pick_velocity();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return VEL_W'($urandom_range(0, 65535));
	endfunction

	// watchdog: count cycles with no word moving on either channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stall_cycles <= 0;
		else if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_samples.size() == 0) begin
				$display("%0t: unexpected sample_out %0d", $time, $signed(sample_out));
				mismatches++;
			end else begin
				want = expected_samples.pop_front();
				if (sample_out !== want) begin
					$display("%0t: sample_out expected %0d actual %0d", $time,
						$signed(want), $signed(sample_out));
					mismatches++;
				end
			end
		end
	end

	// receiver: stall in bursts, with a random idle rate that is redrawn periodically
	initial begin
		int stall;
		int rx_idle_pct;
		int cyc;
		out_ready   = 1'b0;
		rx_idle_pct = 4;
		cyc         = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 128 == 0)
				rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(4, 20);
			if (!quiet_tail && $urandom_range(0, 99) < rx_idle_pct) begin
				stall = $urandom_range(1, 18);
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	initial begin
		int          n;
		int          r;
		logic [PITCH_W-1:0] p;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		req_type      = REQ_TICK;
		note_pitch    = '0;
		note_velocity = '0;
		mismatches    = 0;
		words_sent    = 0;
		quiet_tail    = 1'b0;
		voice_active  = 1'b0;
		held_note     = '0;
		phase         = '0;
		phase_inc     = '0;
		gain_q16      = '0;

		add_row(REQ_TICK,      0,   0,       1'b1, 16'sd0);
		add_row(REQ_NOTE_OFF,  0,   0,       1'b0, '0);
		add_row(REQ_TICK,      127, 'hFFFF,  1'b1, 16'sd0);
		add_row(REQ_NOTE_ON,   69,  0,       1'b0, '0);
		add_row(REQ_TICK,      0,   0,       1'b1, 16'sd0);
		add_row(REQ_NOTE_ON,   69,  'hFFFF,  1'b0, '0);
		add_row(REQ_TICK,      0,   0,       1'b1, -16'sd6553);
		add_row(REQ_TICK,      0,   0,       1'b0, '0);
		add_row(REQ_TICK,      0,   0,       1'b0, '0);
		add_row(REQ_NOTE_OFF,  70,  0,       1'b0, '0);
		add_row(REQ_TICK,      0,   0,       1'b0, '0);
		add_row(REQ_NOTE_OFF,  69,  'hFFFF,  1'b0, '0);
		add_row(REQ_TICK,      0,   0,       1'b1, 16'sd0);
		add_row(REQ_NOTE_ON,   127, 1,       1'b0, '0);
		add_row(REQ_TICK,      0,   0,       1'b1, 16'sd0);
		add_row(REQ_TICK,      0,   0,       1'b1, 16'sd0);
		add_row(REQ_NOTE_ON,   0,   'hFFFF,  1'b0, '0);
		add_row(REQ_TICK,      0,   0,       1'b1, -16'sd6553);
		add_row(REQ_TICK,      0,   0,       1'b0, '0);
		add_row(REQ_UNUSED,    127, 'hFFFF,  1'b0, '0);
		add_row(REQ_TICK,      0,   0,       1'b0, '0);
		add_row(REQ_NOTE_ON,   127, 'h8000,  1'b0, '0);
		add_row(REQ_TICK,      0,   0,       1'b0, '0);
		add_row(REQ_NOTE_OFF,  127, 0,       1'b0, '0);
		add_row(REQ_TICK,      0,   0,       1'b1, 16'sd0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			issue_word(directed_rows[i].kind, directed_rows[i].pitch, directed_rows[i].vel,
				directed_rows[i].has_exp, directed_rows[i].exp_sample);

		// mostly note phrases (on, ticks, off), with single noise words mixed in
		while (words_sent < N_ITEMS) begin
			if ($urandom_range(0, 9) < 8) begin
				p = PITCH_W'($urandom_range(0, 127));
				issue_word(REQ_NOTE_ON, p, pick_velocity(), 1'b0, '0);
				n = $urandom_range(1, 40);
				repeat (n)
					issue_word(REQ_TICK, PITCH_W'($urandom), VEL_W'($urandom), 1'b0, '0);
				r = $urandom_range(0, 9);
				if (r < 6)
					issue_word(REQ_NOTE_OFF, p, VEL_W'($urandom), 1'b0, '0);
				else if (r < 8)
					issue_word(REQ_NOTE_OFF, PITCH_W'($urandom), VEL_W'($urandom), 1'b0, '0);
			end else begin
				issue_word(2'($urandom_range(0, 3)), PITCH_W'($urandom), pick_velocity(),
					1'b0, '0);
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (expected_samples.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_samples.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[files.f]
+incdir+design
design/nso_pkg.sv
design/nso_front.sv
design/nso_queue.sv
design/nso_back.sv
design/note_saw_oscillator_top.sv
tb/tb_note_saw_oscillator_top.sv
